// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the altitude query block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge outside reset
`define HFAQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// expression must never be true outside reset
`define HFAQ_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define HFAQ_ASSERT(lbl, clk, rst_n, prop)
`define HFAQ_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// File: sv/hfaq_pkg.sv
// ----------------------------------------------------------------------------
// hfaq_pkg
// Types and constants shared by the altitude query controller and datapath.
// ----------------------------------------------------------------------------
package hfaq_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_ORIGIN_X   = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Z   = 3'd1;
    localparam logic [2:0] CFG_INV_CELL_X = 3'd2;
    localparam logic [2:0] CFG_INV_CELL_Z = 3'd3;
    localparam logic [2:0] CFG_QUADS_X    = 3'd4;
    localparam logic [2:0] CFG_QUADS_Z    = 3'd5;
    localparam logic [2:0] CFG_FLAT_MODE  = 3'd6;

    // item opcodes
    localparam logic OPC_LOAD  = 1'b0;
    localparam logic OPC_QUERY = 1'b1;

    localparam int  STORE_AW   = 12;
    localparam int  STORE_DEPTH = 1 << STORE_AW;
    localparam logic [15:0] NRM_ONE = 16'sd32767;

    // datapath operations
    typedef enum logic [4:0] {
        OP_NOP,
        OP_WRITE,
        OP_CAPTURE,
        OP_DIFF,
        OP_LOCX,
        OP_LOCZ,
        OP_CELL,
        OP_READ,
        OP_EDGE,
        OP_INT1,
        OP_INT2,
        OP_SLX,
        OP_SLZ,
        OP_NORM,
        OP_SQ,
        OP_SQRT,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_END,
        OP_EMIT_NRM,
        OP_EMIT_FLAT,
        OP_EMIT_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [1:0] sel;
    } t_cmd;

    typedef struct packed {
        logic flat;
        logic in_range;
        logic big;
        logic out_free;
    } t_sts;

endpackage

// File: sv/hfaq_datapath.sv
// ----------------------------------------------------------------------------
// hfaq_datapath
// Configuration, height store, locate/interpolate arithmetic, normal
// normalization (square root and division) and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hfaq_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    input  logic signed [31:0]  i_pos_x,
    input  logic signed [31:0]  i_pos_z,
    input  logic [11:0]         i_vertex_index,
    input  logic signed [31:0]  i_height_value,
    input  hfaq_pkg::t_cmd      i_cmd,
    output hfaq_pkg::t_sts      o_sts,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output logic signed [31:0]  o_altitude,
    output logic                o_in_range,
    output logic signed [15:0]  o_normal_x,
    output logic signed [15:0]  o_normal_y,
    output logic signed [15:0]  o_normal_z
);

    // configuration
    logic signed [31:0] r_org_x, r_org_z;
    logic [31:0]        r_inv_x, r_inv_z;
    logic [5:0]         r_qx, r_qz;
    logic               r_flat;

    // query state
    logic signed [31:0] r_pos_x, r_pos_z;
    logic [32:0]        r_magx, r_magz;
    logic               r_negx, r_negz;
    logic [63:0]        r_px, r_pz;
    logic [11:0]        r_i0;
    logic [6:0]         r_rows;
    logic [15:0]        r_fx, r_fz;
    logic signed [31:0] r_h [4];
    logic               r_lower;
    logic signed [32:0] r_ea, r_eb;
    logic signed [31:0] r_base;
    logic [16:0]        r_wa, r_wb;
    logic signed [52:0] r_acc;
    logic [63:0]        r_m [3];
    logic               r_ng [3];
    logic [63:0]        r_sum, r_root, r_bit;
    logic [33:0]        r_drem;
    logic [16:0]        r_dn, r_q;
    logic [15:0]        r_nrm [3];

    logic               r_out_valid;
    logic signed [31:0] r_out_alt;
    logic               r_out_rng;
    logic [15:0]        r_out_nx, r_out_ny, r_out_nz;

    logic signed [31:0] r_mem [hfaq_pkg::STORE_DEPTH];

    // ---------------- combinational helpers ----------------
    logic signed [32:0] w_dx, w_dz;
    logic [31:0]        w_ma, w_mb;
    logic               w_mhi;
    logic [63:0]        w_prod;
    logic [32:0]        w_abs_ea, w_abs_eb;
    logic [16:0]        w_wsel;
    logic signed [32:0] w_esel;
    logic signed [50:0] w_imul;
    logic signed [52:0] w_fl;
    logic signed [31:0] w_alt;
    logic               w_xok, w_zok;
    logic [6:0]         w_rows;
    logic [12:0]        w_i0;
    logic [11:0]        w_addr;
    logic [16:0]        w_fsum;
    logic               w_lower;
    logic [63:0]        w_msel;
    logic [63:0]        w_rb;
    logic [31:0]        w_root32;
    logic [46:0]        w_n;
    logic [33:0]        w_t;
    logic [14:0]        w_c;

    assign w_dx = 33'(r_pos_x) - 33'(r_org_x);
    assign w_dz = 33'(r_org_z) - 33'(r_pos_z);

    assign w_abs_ea = r_ea[32] ? 33'(-r_ea) : r_ea;
    assign w_abs_eb = r_eb[32] ? 33'(-r_eb) : r_eb;
    assign w_msel   = r_m[i_cmd.sel];

    // shared 32x32 unsigned multiplier; a 33-bit magnitude adds b<<32
    always_comb begin
        w_ma  = '0;
        w_mb  = '0;
        w_mhi = 1'b0;
        unique case (i_cmd.op)
            hfaq_pkg::OP_LOCX: begin
                w_ma = r_magx[31:0]; w_mb = r_inv_x; w_mhi = r_magx[32];
            end
            hfaq_pkg::OP_LOCZ: begin
                w_ma = r_magz[31:0]; w_mb = r_inv_z; w_mhi = r_magz[32];
            end
            hfaq_pkg::OP_SLX: begin
                w_ma = w_abs_ea[31:0]; w_mb = r_inv_x; w_mhi = w_abs_ea[32];
            end
            hfaq_pkg::OP_SLZ: begin
                w_ma = w_abs_eb[31:0]; w_mb = r_inv_z; w_mhi = w_abs_eb[32];
            end
            hfaq_pkg::OP_SQ: begin
                w_ma = w_msel[31:0]; w_mb = w_msel[31:0];
            end
            default: begin
                w_ma = '0;
            end
        endcase
    end
    assign w_prod = ({32'h0, w_ma} * {32'h0, w_mb}) + (w_mhi ? {w_mb, 32'h0} : 64'h0);

    // interpolation multiplier: weight times height difference
    assign w_wsel = (i_cmd.op == hfaq_pkg::OP_INT2) ? r_wb : r_wa;
    assign w_esel = (i_cmd.op == hfaq_pkg::OP_INT2) ? r_eb : r_ea;
    assign w_imul = $signed({1'b0, w_wsel}) * w_esel;

    // floor to Q16.16 and saturate
    assign w_fl = r_acc >>> 16;
    always_comb begin
        if (w_fl > 53'sh0_7FFF_FFFF) begin
            w_alt = 32'sh7FFF_FFFF;
        end else if (w_fl < -53'sh0_8000_0000) begin
            w_alt = 32'sh8000_0000;
        end else begin
            w_alt = w_fl[31:0];
        end
    end

    assign w_xok = !(r_negx && (r_px != 64'h0)) && (r_px[63:32] < {26'h0, r_qx});
    assign w_zok = !(r_negz && (r_pz != 64'h0)) && (r_pz[63:32] < {26'h0, r_qz});

    assign w_rows = {1'b0, r_qz} + 7'd1;
    assign w_i0   = 13'({7'h0, r_px[37:32]} * {6'h0, w_rows}) + {7'h0, r_pz[37:32]};

    always_comb begin
        unique case (i_cmd.sel)
            2'd0:    w_addr = r_i0;
            2'd1:    w_addr = r_i0 + {5'h0, r_rows};
            2'd2:    w_addr = r_i0 + {5'h0, r_rows} + 12'd1;
            default: w_addr = r_i0 + 12'd1;
        endcase
    end

    assign w_fsum  = {1'b0, r_fx} + {1'b0, r_fz};
    assign w_lower = !w_fsum[16];

    assign w_rb     = r_root + r_bit;
    assign w_root32 = r_root[31:0];
    assign w_n      = {1'b0, w_msel[30:0], 15'h0} + {16'h0, w_root32[31:1]};
    assign w_t      = {r_drem[32:0], r_dn[16]};
    assign w_c      = (w_root32 == 32'h0) ? 15'h0 :
                      ((r_q[16:15] != 2'b00) ? 15'h7FFF : r_q[14:0]);

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x <= '0;
            r_org_z <= '0;
            r_inv_x <= 32'h0001_0000;
            r_inv_z <= 32'h0001_0000;
            r_qx    <= 6'd1;
            r_qz    <= 6'd1;
            r_flat  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                hfaq_pkg::CFG_ORIGIN_X:   r_org_x <= i_cfg_data;
                hfaq_pkg::CFG_ORIGIN_Z:   r_org_z <= i_cfg_data;
                hfaq_pkg::CFG_INV_CELL_X: r_inv_x <= i_cfg_data;
                hfaq_pkg::CFG_INV_CELL_Z: r_inv_z <= i_cfg_data;
                hfaq_pkg::CFG_QUADS_X:    r_qx    <= i_cfg_data[5:0];
                hfaq_pkg::CFG_QUADS_Z:    r_qz    <= i_cfg_data[5:0];
                hfaq_pkg::CFG_FLAT_MODE:  r_flat  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // ---------------- height store ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == hfaq_pkg::OP_WRITE) begin
            r_mem[i_vertex_index] <= i_height_value;
        end
        if (i_cmd.op == hfaq_pkg::OP_READ) begin
            r_h[i_cmd.sel] <= r_mem[w_addr];
        end
    end

    // ---------------- arithmetic registers ----------------
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            hfaq_pkg::OP_CAPTURE: begin
                r_pos_x <= i_pos_x;
                r_pos_z <= i_pos_z;
            end
            hfaq_pkg::OP_DIFF: begin
                r_negx <= w_dx[32];
                r_negz <= w_dz[32];
                r_magx <= w_dx[32] ? 33'(-w_dx) : w_dx;
                r_magz <= w_dz[32] ? 33'(-w_dz) : w_dz;
            end
            hfaq_pkg::OP_LOCX: r_px <= w_prod;
            hfaq_pkg::OP_LOCZ: r_pz <= w_prod;
            hfaq_pkg::OP_CELL: begin
                r_i0   <= w_i0[11:0];
                r_rows <= w_rows;
                r_fx   <= r_px[31:16];
                r_fz   <= r_pz[31:16];
            end
            hfaq_pkg::OP_EDGE: begin
                r_lower <= w_lower;
                if (w_lower) begin
                    r_ea   <= 33'(r_h[1]) - 33'(r_h[0]);
                    r_eb   <= 33'(r_h[3]) - 33'(r_h[0]);
                    r_base <= r_h[0];
                    r_wa   <= {1'b0, r_fx};
                    r_wb   <= {1'b0, r_fz};
                end else begin
                    r_ea   <= 33'(r_h[3]) - 33'(r_h[2]);
                    r_eb   <= 33'(r_h[1]) - 33'(r_h[2]);
                    r_base <= r_h[2];
                    r_wa   <= 17'h1_0000 - {1'b0, r_fx};
                    r_wb   <= 17'h1_0000 - {1'b0, r_fz};
                end
            end
            hfaq_pkg::OP_INT1: r_acc <= (53'(r_base) <<< 16) + 53'(w_imul);
            hfaq_pkg::OP_INT2: r_acc <= r_acc + 53'(w_imul);
            hfaq_pkg::OP_SLX: begin
                r_m[0]  <= w_prod;
                r_ng[0] <= r_lower ? (!r_ea[32] && (r_ea != '0)) : r_ea[32];
                r_m[1]  <= 64'h1_0000_0000;
                r_ng[1] <= 1'b0;
            end
            hfaq_pkg::OP_SLZ: begin
                r_m[2]  <= w_prod;
                r_ng[2] <= r_lower ? r_eb[32] : (!r_eb[32] && (r_eb != '0));
                r_sum   <= '0;
                r_root  <= '0;
                r_bit   <= 64'h4000_0000_0000_0000;
            end
            hfaq_pkg::OP_NORM: begin
                r_m[0] <= r_m[0] >> 1;
                r_m[1] <= r_m[1] >> 1;
                r_m[2] <= r_m[2] >> 1;
            end
            hfaq_pkg::OP_SQ: r_sum <= r_sum + w_prod;
            hfaq_pkg::OP_SQRT: begin
                if (r_sum >= w_rb) begin
                    r_sum  <= r_sum - w_rb;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            hfaq_pkg::OP_DIV_INIT: begin
                r_drem <= {4'h0, w_n[46:17]};
                r_dn   <= w_n[16:0];
                r_q    <= '0;
            end
            hfaq_pkg::OP_DIV_STEP: begin
                if (w_t >= {2'b00, w_root32}) begin
                    r_drem <= w_t - {2'b00, w_root32};
                    r_q    <= {r_q[15:0], 1'b1};
                end else begin
                    r_drem <= w_t;
                    r_q    <= {r_q[15:0], 1'b0};
                end
                r_dn <= {r_dn[15:0], 1'b0};
            end
            hfaq_pkg::OP_DIV_END: begin
                r_nrm[i_cmd.sel] <= r_ng[i_cmd.sel] ? 16'(16'h0 - {1'b0, w_c})
                                                    : {1'b0, w_c};
            end
            default: begin
            end
        endcase
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_cmd.op == hfaq_pkg::OP_EMIT_NRM) ||
                     (i_cmd.op == hfaq_pkg::OP_EMIT_FLAT) ||
                     (i_cmd.op == hfaq_pkg::OP_EMIT_OUT)) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_cmd.op == hfaq_pkg::OP_EMIT_NRM) begin
            r_out_alt <= w_alt;
            r_out_rng <= 1'b1;
            r_out_nx  <= r_nrm[0];
            r_out_ny  <= r_nrm[1];
            r_out_nz  <= r_nrm[2];
        end else if ((i_cmd.op == hfaq_pkg::OP_EMIT_FLAT) ||
                     (i_cmd.op == hfaq_pkg::OP_EMIT_OUT)) begin
            r_out_alt <= '0;
            r_out_rng <= (i_cmd.op == hfaq_pkg::OP_EMIT_FLAT);
            r_out_nx  <= '0;
            r_out_ny  <= hfaq_pkg::NRM_ONE;
            r_out_nz  <= '0;
        end else begin
        end
    end

    assign o_sts.flat     = r_flat;
    assign o_sts.in_range = w_xok && w_zok;
    assign o_sts.big      = (r_m[0][63:31] != '0) || (r_m[1][63:31] != '0) ||
                            (r_m[2][63:31] != '0);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_altitude  = r_out_alt;
    assign o_in_range  = r_out_rng;
    assign o_normal_x  = r_out_nx;
    assign o_normal_y  = r_out_ny;
    assign o_normal_z  = r_out_nz;

    // division partial remainder stays below the root
    `HFAQ_ASSERT(a_div_rem, i_clk, i_rst_n, (i_cmd.op == hfaq_pkg::OP_DIV_STEP) |-> (r_drem < {2'b00, w_root32}))
    // normalization always has a nonzero root
    `HFAQ_NEVER(a_root_zero, i_clk, i_rst_n, (i_cmd.op == hfaq_pkg::OP_DIV_END) && (w_root32 == 32'h0))
    // a pending result is never overwritten while stalled
    `HFAQ_ASSERT(a_out_hold, i_clk, i_rst_n, (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out_alt)))

endmodule

// File: sv/hfaq_ctrl.sv
// ----------------------------------------------------------------------------
// hfaq_ctrl
// Sequencer that steps the datapath through load, locate, interpolate and
// normalize, and hands finished results to the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hfaq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_op,
    output logic           o_in_stall,
    input  hfaq_pkg::t_sts i_sts,
    output hfaq_pkg::t_cmd o_cmd
);

    typedef enum logic [19:0] {
        S_IDLE      = 20'h00001,
        S_DIFF      = 20'h00002,
        S_LOCX      = 20'h00004,
        S_LOCZ      = 20'h00008,
        S_CHECK     = 20'h00010,
        S_READ      = 20'h00020,
        S_EDGE      = 20'h00040,
        S_INT1      = 20'h00080,
        S_INT2      = 20'h00100,
        S_SLX       = 20'h00200,
        S_SLZ       = 20'h00400,
        S_NORM      = 20'h00800,
        S_SQ        = 20'h01000,
        S_SQRT      = 20'h02000,
        S_DIVI      = 20'h04000,
        S_DIVS      = 20'h08000,
        S_DIVE      = 20'h10000,
        S_EMIT_NRM  = 20'h20000,
        S_EMIT_FLAT = 20'h40000,
        S_EMIT_OUT  = 20'h80000
    } t_state;

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic [1:0] r_sel, n_sel;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_sel      = r_sel;
        o_cmd.op   = hfaq_pkg::OP_NOP;
        o_cmd.sel  = r_sel;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_op == hfaq_pkg::OPC_LOAD) begin
                        o_cmd.op = hfaq_pkg::OP_WRITE;
                    end else begin
                        o_cmd.op = hfaq_pkg::OP_CAPTURE;
                        n_state  = i_sts.flat ? S_EMIT_FLAT : S_DIFF;
                    end
                end
            end
            S_DIFF: begin
                o_cmd.op = hfaq_pkg::OP_DIFF;
                n_state  = S_LOCX;
            end
            S_LOCX: begin
                o_cmd.op = hfaq_pkg::OP_LOCX;
                n_state  = S_LOCZ;
            end
            S_LOCZ: begin
                o_cmd.op = hfaq_pkg::OP_LOCZ;
                n_state  = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.in_range) begin
                    o_cmd.op = hfaq_pkg::OP_CELL;
                    n_sel    = 2'd0;
                    n_state  = S_READ;
                end else begin
                    n_state  = S_EMIT_OUT;
                end
            end
            S_READ: begin
                o_cmd.op = hfaq_pkg::OP_READ;
                n_sel    = r_sel + 2'd1;
                if (r_sel == 2'd3) begin
                    n_state = S_EDGE;
                end
            end
            S_EDGE: begin
                o_cmd.op = hfaq_pkg::OP_EDGE;
                n_state  = S_INT1;
            end
            S_INT1: begin
                o_cmd.op = hfaq_pkg::OP_INT1;
                n_state  = S_INT2;
            end
            S_INT2: begin
                o_cmd.op = hfaq_pkg::OP_INT2;
                n_state  = S_SLX;
            end
            S_SLX: begin
                o_cmd.op = hfaq_pkg::OP_SLX;
                n_state  = S_SLZ;
            end
            S_SLZ: begin
                o_cmd.op = hfaq_pkg::OP_SLZ;
                n_state  = S_NORM;
            end
            S_NORM: begin
                if (i_sts.big) begin
                    o_cmd.op = hfaq_pkg::OP_NORM;
                end else begin
                    n_sel   = 2'd0;
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                o_cmd.op = hfaq_pkg::OP_SQ;
                if (r_sel == 2'd2) begin
                    n_sel   = 2'd0;
                    n_cnt   = '0;
                    n_state = S_SQRT;
                end else begin
                    n_sel = r_sel + 2'd1;
                end
            end
            S_SQRT: begin
                o_cmd.op = hfaq_pkg::OP_SQRT;
                n_cnt    = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_state = S_DIVI;
                end
            end
            S_DIVI: begin
                o_cmd.op = hfaq_pkg::OP_DIV_INIT;
                n_cnt    = '0;
                n_state  = S_DIVS;
            end
            S_DIVS: begin
                o_cmd.op = hfaq_pkg::OP_DIV_STEP;
                n_cnt    = r_cnt + 5'd1;
                if (r_cnt == 5'd16) begin
                    n_state = S_DIVE;
                end
            end
            S_DIVE: begin
                o_cmd.op = hfaq_pkg::OP_DIV_END;
                if (r_sel == 2'd2) begin
                    n_state = S_EMIT_NRM;
                end else begin
                    n_sel   = r_sel + 2'd1;
                    n_state = S_DIVI;
                end
            end
            S_EMIT_NRM: begin
                if (i_sts.out_free) begin
                    o_cmd.op = hfaq_pkg::OP_EMIT_NRM;
                    n_state  = S_IDLE;
                end
            end
            S_EMIT_FLAT: begin
                if (i_sts.out_free) begin
                    o_cmd.op = hfaq_pkg::OP_EMIT_FLAT;
                    n_state  = S_IDLE;
                end
            end
            S_EMIT_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.op = hfaq_pkg::OP_EMIT_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_sel   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_sel   <= n_sel;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    // results are only handed over when the output register can take them
    `HFAQ_NEVER(a_emit_free, i_clk, i_rst_n, ((o_cmd.op == hfaq_pkg::OP_EMIT_NRM) || (o_cmd.op == hfaq_pkg::OP_EMIT_FLAT) || (o_cmd.op == hfaq_pkg::OP_EMIT_OUT)) && !i_sts.out_free)
    // the store is only read for points inside the grid
    `HFAQ_ASSERT(a_read_range, i_clk, i_rst_n, (o_cmd.op == hfaq_pkg::OP_READ) |-> i_sts.in_range)
    // an accepted query always leaves idle
    `HFAQ_ASSERT(a_query_busy, i_clk, i_rst_n, (i_in_valid && !o_in_stall && (i_op == hfaq_pkg::OPC_QUERY)) |=> o_in_stall)

endmodule

// File: sv/heightfield_altitude_query.sv
// ----------------------------------------------------------------------------
// heightfield_altitude_query
// Height grid with triangle interpolation and unit surface normal per query.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake               beat content
//  -------   ---------  ----------------------  ----------------------------------
//  in        sink       i_in_valid / o_in_stall  op, pos_x, pos_z, vertex_index,
//                                                height_value
//  out       source     o_out_valid / i_out_stall altitude, in_range, normal_x/y/z
//  cfg       sink       i_cfg_we (no wait)       i_cfg_index, i_cfg_data
//
//  A load beat is a single store write. An on-grid query runs four store
//  reads, up to 33 normalizing shifts, a 32-step square root and three
//  17-step divides, all on one shared datapath.
//  Reset is synchronous and active low; it restores register defaults but
//  leaves the height store unset. A finished result waits in the output
//  register under stall while the next beat is already taken in.
// ----------------------------------------------------------------------------

module heightfield_altitude_query (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_op,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_z,
    input  logic [11:0]        i_vertex_index,
    input  logic signed [31:0] i_height_value,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_altitude,
    output logic               o_in_range,
    output logic signed [15:0] o_normal_x,
    output logic signed [15:0] o_normal_y,
    output logic signed [15:0] o_normal_z
);

    hfaq_pkg::t_cmd w_cmd;
    hfaq_pkg::t_sts w_sts;

    // sequencer: one beat at a time, issues at most one datapath operation per cycle
    hfaq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // arithmetic, height store and result register
    hfaq_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_pos_x        (i_pos_x),
        .i_pos_z        (i_pos_z),
        .i_vertex_index (i_vertex_index),
        .i_height_value (i_height_value),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_altitude     (o_altitude),
        .o_in_range     (o_in_range),
        .o_normal_x     (o_normal_x),
        .o_normal_y     (o_normal_y),
        .o_normal_z     (o_normal_z)
    );

endmodule

// File: bench/hfaq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfaq_checker
// Watches the config port and both channels of the altitude query block, keeps
// its own height grid and register copy, predicts every query result and
// compares each output beat against the oldest prediction.
// ----------------------------------------------------------------------------
module hfaq_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic               i_op,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_z,
    input  logic [11:0]        i_vertex_index,
    input  logic signed [31:0] i_height_value,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [31:0] i_altitude,
    input  logic               i_in_range,
    input  logic signed [15:0] i_normal_x,
    input  logic signed [15:0] i_normal_y,
    input  logic signed [15:0] i_normal_z,
    output int                 o_fail_count,
    output int                 o_waiting
);

    typedef struct packed {
        logic [31:0] altitude;
        logic        in_range;
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
    } t_answer;

    logic signed [31:0] grid_h [hfaq_pkg::STORE_DEPTH];
    logic [31:0] org_x, org_z, rcp_x, rcp_z;
    logic [5:0]  cells_x, cells_z;
    logic        flat;
    t_answer     answers [$];

    function automatic logic [63:0] sqrt_floor(input logic [63:0] s);
        logic [63:0] r, b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // map an offset onto a grid index and a Q0.16 fraction; 0 when off grid
    function automatic bit find_cell(input longint d, input logic [31:0] rcp,
                                     input logic [5:0] cells, output int unsigned slot,
                                     output int unsigned frac);
        logic [63:0] mag, p;
        mag = (d < 0) ? 64'(-d) : 64'(d);
        p = mag * {32'd0, rcp};
        slot = 0;
        frac = 0;
        if (d < 0 && p != 0) return 0;
        if (p[63:32] >= {58'd0, cells}) return 0;
        slot = p[63:32];
        frac = p[31:16];
        return 1;
    endfunction

    function automatic t_answer altitude_at(input logic [31:0] px, input logic [31:0] pz);
        t_answer a;
        int unsigned cx, cz, fx, fz, rows, v0, v1, v2, v3;
        longint h0, h1, h2, h3, acc, alt, dx, dz;
        logic [63:0] m [3];
        bit          ng [3];
        logic [63:0] top, ss, r, c;
        int          k;
        a = '{altitude: 32'd0, in_range: 1'b1, nx: 16'd0, ny: hfaq_pkg::NRM_ONE,
              nz: 16'd0};
        if (flat) return a;
        if (!find_cell(longint'($signed(px)) - longint'($signed(org_x)), rcp_x, cells_x,
                       cx, fx) ||
            !find_cell(longint'($signed(org_z)) - longint'($signed(pz)), rcp_z, cells_z,
                       cz, fz)) begin
            a.in_range = 1'b0;
            return a;
        end
        rows = cells_z + 1;
        v0 = cx * rows + cz;
        v1 = v0 + rows;
        v2 = v1 + 1;
        v3 = v0 + 1;
        h0 = grid_h[v0[11:0]];
        h1 = grid_h[v1[11:0]];
        h2 = grid_h[v2[11:0]];
        h3 = grid_h[v3[11:0]];
        if (fx + fz < 65536) begin
            acc = h0 * 65536 + longint'(fx) * (h1 - h0) + longint'(fz) * (h3 - h0);
            dx = h0 - h1;
            dz = h3 - h0;
        end else begin
            acc = h2 * 65536 + longint'(65536 - fx) * (h3 - h2)
                + longint'(65536 - fz) * (h1 - h2);
            dx = h3 - h2;
            dz = h2 - h1;
        end
        alt = acc >>> 16;
        if (alt > 64'sd2147483647) alt = 64'sd2147483647;
        if (alt < -64'sd2147483648) alt = -64'sd2147483648;
        a.altitude = alt[31:0];
        // slope magnitudes in Q32.32, signs kept aside
        ng[0] = dx < 0;
        ng[1] = 0;
        ng[2] = dz < 0;
        m[0] = (ng[0] ? 64'(-dx) : 64'(dx)) * {32'd0, rcp_x};
        m[1] = 64'd1 << 32;
        m[2] = (ng[2] ? 64'(-dz) : 64'(dz)) * {32'd0, rcp_z};
        top = m[0];
        if (m[1] > top) top = m[1];
        if (m[2] > top) top = m[2];
        k = 0;
        while ((top >> k) >= (64'd1 << 31)) k++;
        ss = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = m[i] >> k;
            ss = ss + m[i] * m[i];
        end
        r = sqrt_floor(ss);
        for (int i = 0; i < 3; i++) begin
            c = (r == 0) ? 64'd0 : (m[i] * 64'd32768 + r / 2) / r;
            if (c > 64'd32767) c = 64'd32767;
            if (ng[i]) c = -c;
            if (i == 0) a.nx = c[15:0];
            else if (i == 1) a.ny = c[15:0];
            else a.nz = c[15:0];
        end
        return a;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_waiting = 0;
    end

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            org_x <= 32'd0;
            org_z <= 32'd0;
            rcp_x <= 32'd65536;
            rcp_z <= 32'd65536;
            cells_x <= 6'd1;
            cells_z <= 6'd1;
            flat <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    hfaq_pkg::CFG_ORIGIN_X:   org_x <= i_cfg_data;
                    hfaq_pkg::CFG_ORIGIN_Z:   org_z <= i_cfg_data;
                    hfaq_pkg::CFG_INV_CELL_X: rcp_x <= i_cfg_data;
                    hfaq_pkg::CFG_INV_CELL_Z: rcp_z <= i_cfg_data;
                    hfaq_pkg::CFG_QUADS_X:    cells_x <= i_cfg_data[5:0];
                    hfaq_pkg::CFG_QUADS_Z:    cells_z <= i_cfg_data[5:0];
                    hfaq_pkg::CFG_FLAT_MODE:  flat <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_op == hfaq_pkg::OPC_QUERY) answers.push_back(altitude_at(i_pos_x, i_pos_z));
                else grid_h[i_vertex_index] = i_height_value;
            end
            if (i_out_valid && !i_out_stall) begin
                if (answers.size() == 0) begin
                    $display("%0t: unexpected result beat altitude %h", $time, i_altitude);
                    o_fail_count++;
                end else begin
                    want = answers.pop_front();
                    compare_field("altitude", want.altitude, i_altitude);
                    compare_field("in_range", {31'd0, want.in_range}, {31'd0, i_in_range});
                    compare_field("normal_x", {16'd0, want.nx}, {16'd0, i_normal_x});
                    compare_field("normal_y", {16'd0, want.ny}, {16'd0, i_normal_y});
                    compare_field("normal_z", {16'd0, want.nz}, {16'd0, i_normal_z});
                end
            end
            o_waiting <= answers.size();
        end
    end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the altitude query block: fills every height the phases can
// reach, runs a directed set on the reset grid, then random phases under
// several register settings, most with random gaps and output stalls. The checker
// does the scoring.
// ----------------------------------------------------------------------------
module tb;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               op = hfaq_pkg::OPC_LOAD;
    logic signed [31:0] pos_x = '0;
    logic signed [31:0] pos_z = '0;
    logic [11:0]        vertex_index = '0;
    logic signed [31:0] height_value = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] altitude;
    logic               in_range;
    logic signed [15:0] normal_x, normal_y, normal_z;
    int                 fail_count, waiting;

    // tb-side copy of the registers, used only to aim queries at the grid
    logic [31:0] org_x = 0, org_z = 0, rcp_x = 65536, rcp_z = 65536;
    logic [5:0]  cells_x = 1, cells_z = 1;
    bit          calm;        // no gaps and no stalls while set
    int          stall_left = 0;
    longint      cycles = 0;

    localparam longint CYCLE_LIMIT = 3_000_000;
    // every phase keeps (quads_x+1)*(quads_z+1) within this many vertices
    localparam int     FILL_COUNT  = 256;

    always #5 clk = ~clk;

    heightfield_altitude_query dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_op(op), .i_pos_x(pos_x), .i_pos_z(pos_z),
        .i_vertex_index(vertex_index), .i_height_value(height_value),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_altitude(altitude), .o_in_range(in_range),
        .o_normal_x(normal_x), .o_normal_y(normal_y), .o_normal_z(normal_z)
    );

    hfaq_checker chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_op(op), .i_pos_x(pos_x), .i_pos_z(pos_z),
        .i_vertex_index(vertex_index), .i_height_value(height_value),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_altitude(altitude), .i_in_range(in_range),
        .i_normal_x(normal_x), .i_normal_y(normal_y), .i_normal_z(normal_z),
        .o_fail_count(fail_count), .o_waiting(waiting)
    );

    // Receiver: after each taken beat, draw how long to hold off the next one.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (out_valid && !out_stall) begin
            stall_left = calm ? 0 : $urandom_range(0, 18);
            out_stall <= (stall_left != 0);
        end else if (stall_left > 0) begin
            stall_left--;
            out_stall <= (stall_left != 0);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Drive one beat: idle for a random gap, then hold it until taken.
    task automatic send_beat(input logic o, input logic [31:0] px, input logic [31:0] pz,
                             input logic [11:0] vi, input logic [31:0] hv);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        pos_x <= px;
        pos_z <= pz;
        vertex_index <= vi;
        height_value <= hv;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic load_height(input logic [11:0] vi, input logic [31:0] hv);
        send_beat(hfaq_pkg::OPC_LOAD, $urandom, $urandom, vi, hv);
    endtask

    task automatic query_at(input logic [31:0] px, input logic [31:0] pz);
        send_beat(hfaq_pkg::OPC_QUERY, px, pz, $urandom, $urandom);
    endtask

    // Drop valid, wait for every result, then let a trailing load finish.
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (waiting != 0) @(posedge clk);
        repeat (160) @(posedge clk);
    endtask

    // One write, then the enable drops before the next write.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            hfaq_pkg::CFG_ORIGIN_X:   org_x = val;
            hfaq_pkg::CFG_ORIGIN_Z:   org_z = val;
            hfaq_pkg::CFG_INV_CELL_X: rcp_x = val;
            hfaq_pkg::CFG_INV_CELL_Z: rcp_z = val;
            hfaq_pkg::CFG_QUADS_X:    cells_x = val[5:0];
            hfaq_pkg::CFG_QUADS_Z:    cells_z = val[5:0];
            default: ;
        endcase
    endtask

    task automatic set_phase(input logic [31:0] ox, input logic [31:0] oz,
                             input logic [31:0] rx, input logic [31:0] rz,
                             input logic [5:0] qx, input logic [5:0] qz, input logic fl);
        write_reg(hfaq_pkg::CFG_ORIGIN_X, ox);
        write_reg(hfaq_pkg::CFG_ORIGIN_Z, oz);
        write_reg(hfaq_pkg::CFG_INV_CELL_X, rx);
        write_reg(hfaq_pkg::CFG_INV_CELL_Z, rz);
        write_reg(hfaq_pkg::CFG_QUADS_X, {26'd0, qx});
        write_reg(hfaq_pkg::CFG_QUADS_Z, {26'd0, qz});
        write_reg(hfaq_pkg::CFG_FLAT_MODE, {31'd0, fl});
    endtask

    // Mostly small heights keep normals steep enough to be interesting.
    function automatic logic [31:0] pick_height;
        if ($urandom_range(0, 3) == 0) return $urandom;
        return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
    endfunction

    // Offset that lands in a random cell at a random fraction along one axis.
    function automatic longint aim(input logic [31:0] rcp, input logic [5:0] cells);
        logic [63:0] u;
        u = {32'($urandom_range(0, cells - 1)), 32'($urandom)};
        return longint'(u / {32'd0, rcp});
    endfunction

    task automatic random_phase(input int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                query_at(32'(longint'($signed(org_x)) + aim(rcp_x, cells_x)),
                         32'(longint'($signed(org_z)) - aim(rcp_z, cells_z)));
            else if (pick < 75)
                query_at($urandom, $urandom);
            else
                load_height($urandom, pick_height());
        end
        drain();
    endtask

    initial begin
        calm = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill every vertex a query can reach so none reads an unset entry.
        calm = 1'b1;
        for (int v = 0; v < FILL_COUNT; v++) load_height(v[11:0], pick_height());
        calm = 1'b0;

        // Directed: reset grid is one cell, vertices 0..3.
        load_height(12'd0, 32'h7FFF_FFFF);
        load_height(12'd1, 32'h8000_0000);
        load_height(12'd2, 32'h8000_0000);
        load_height(12'd3, 32'h7FFF_FFFF);
        query_at(32'h0000_4000, 32'hFFFF_C000);    // lower triangle, extreme heights
        query_at(32'h0000_C000, 32'hFFFF_4000);    // upper triangle
        load_height(12'd0, 32'h0001_0000);
        load_height(12'd1, 32'h0000_0000);
        load_height(12'd2, 32'h0003_0000);
        load_height(12'd3, 32'hFFFE_0000);
        query_at(32'h0000_0000, 32'h0000_0000);    // on vertex zero
        query_at(32'h0000_8000, 32'hFFFF_8000);    // fractions sum to exactly one
        query_at(32'h0000_FFFF, 32'hFFFF_0001);    // far corner of the cell
        query_at(32'hFFFF_FFFF, 32'hFFFF_8000);    // just left of the grid
        query_at(32'h0001_0000, 32'hFFFF_8000);    // x at the quad count
        query_at(32'h0000_8000, 32'h0000_0001);    // z on the wrong side of origin
        query_at(32'h7FFF_FFFF, 32'h8000_0000);    // field extremes
        query_at(32'h8000_0000, 32'h7FFF_FFFF);
        drain();                                   // sender waits for all results
        write_reg(hfaq_pkg::CFG_FLAT_MODE, 32'd1);
        query_at(32'h0000_4000, 32'hFFFF_C000);    // flat terrain
        query_at(32'h7FFF_FFFF, 32'h7FFF_FFFF);    // flat wins even off grid
        drain();

        // Random phases, extremes among the settings.
        set_phase(32'd0, 32'd0, 32'd65536, 32'd65536, 6'd15, 6'd15, 1'b0);
        random_phase(320);
        calm = 1'b1;
        set_phase(32'hFFFB_0000, 32'h0007_0000, 32'd32768, 32'd131072, 6'd10, 6'd20, 1'b0);
        random_phase(260);
        calm = 1'b0;
        set_phase(32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'hFFFF_FFFF, 6'd1, 6'd63, 1'b0);
        random_phase(300);
        set_phase($urandom_range(0, 1 << 20), $urandom_range(0, 1 << 20), 32'd65536,
                  32'd16384, 6'd1, 6'd63, 1'b1);
        random_phase(120);
        set_phase($urandom, $urandom, $urandom_range(1 << 12, 1 << 18),
                  $urandom_range(1 << 12, 1 << 18), $urandom_range(1, 15),
                  $urandom_range(1, 15), 1'b0);
        random_phase(340);
        set_phase(32'd0, 32'd0, 32'd65536, 32'd65536, 6'd63, 6'd1, 1'b0);
        random_phase(280);

        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
